// File: design/srcc_pkg.sv
// ----------------------------------------------------------------------------
// srcc_pkg: shared types and constants of the stored record checker
// crc step, header constants, status codes and queue entry format
// ----------------------------------------------------------------------------
package srcc_pkg;

   localparam int unsigned MaxPayload = 4096;
   localparam logic [31:0] CrcPoly    = 32'hedb88320;
   localparam logic [12:0] HdrSize    = 13'd24;
   localparam logic [12:0] CrcHdrEnd  = 13'd20;
   localparam logic [6:0]  KeyMax     = 7'd64;
   localparam logic [12:0] OffsetMax  = 13'd8191;
   localparam logic [7:0]  MagicR     = 8'h52;
   localparam logic [7:0]  MagicN     = 8'h4e;
   localparam logic [7:0]  MagicS     = 8'h53;

   localparam logic [0:0] FuncKey    = 1'b0;
   localparam logic [0:0] FuncRecord = 1'b1;
   localparam logic [0:0] KindPayload = 1'b0;
   localparam logic [0:0] KindStatus  = 1'b1;

   localparam logic [0:0] CsrVersion  = 1'b0;
   localparam logic [0:0] CsrCapacity = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_KEY   = 2'd1,
      ST_MALFORMED = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   // entry from the front part to the back part
   typedef struct packed {
      logic        func;
      logic [7:0]  data_byte;
      logic        last;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [1:0]  status;
      logic [31:0] generation;
      logic [12:0] stated_length;
      logic        final_res;
   } result_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
      end
      return c;
   endfunction

endpackage

// File: design/srcc_if.sv
// ----------------------------------------------------------------------------
// srcc_if: valid/ready channel interfaces
// request, response and configuration channels
// ----------------------------------------------------------------------------
interface srcc_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   logic       last;
   modport source (output valid, func, data_byte, last, input ready);
   modport sink   (input valid, func, data_byte, last, output ready);
endinterface

interface srcc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [1:0]  status;
   logic [31:0] generation;
   logic [12:0] stated_length;
   logic        final_res;
   modport source (output valid, kind, payload_byte, status, generation,
                   stated_length, final_res, input ready);
   modport sink   (input valid, kind, payload_byte, status, generation,
                   stated_length, final_res, output ready);
endinterface

interface srcc_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/srcc_queue.sv
// ----------------------------------------------------------------------------
// srcc_queue: four-entry queue between front and back
// registered storage with valid/ready on both sides
// ----------------------------------------------------------------------------
module srcc_queue import srcc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_data
);
   item_type   mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 3'd4);
   assign pop_valid  = (count_ff != 3'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push};
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: design/srcc_back.sv
// ----------------------------------------------------------------------------
// srcc_back: record checking engine
// key tag, header checks, crc and final status, with a two-slot output stage
// ----------------------------------------------------------------------------
module srcc_back import srcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] record_version,
   input  logic [12:0] output_capacity,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_data,
   srcc_rsp_if.source  rsp
);
   logic [6:0]  key_count_ff, key_count_in;
   logic [31:0] key_crc_ff, key_crc_in;
   logic [12:0] byte_offset_ff, byte_offset_in;
   logic [31:0] record_crc_ff, record_crc_in;
   logic        header_bad_ff, header_bad_in;
   logic [31:0] decl_len_ff, decl_len_in;
   logic [31:0] gen_ff, gen_in;
   logic [31:0] chk_ff, chk_in;

   // output stage: up to two results (payload then status)
   result_type  slot_ff [2];
   result_type  slot_in [2];
   logic [1:0]  cnt_ff, cnt_in;

   result_type  pay_res, sta_res;
   logic        want_pay, want_sta, take, pop;
   logic [12:0] pos;
   logic [31:0] crc_step, tag;
   logic [7:0]  b, expect_b;
   logic        check_b;
   logic [1:0]  st;
   logic [31:0] g_out;
   logic [12:0] l_out;

   assign pop      = rsp.valid && rsp.ready;
   // accept when there is room for two results after this cycle's pop
   assign in_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   assign take     = in_valid && in_ready;
   assign rsp.valid          = (cnt_ff != 2'd0);
   assign rsp.kind           = slot_ff[0].kind;
   assign rsp.payload_byte   = slot_ff[0].payload_byte;
   assign rsp.status         = slot_ff[0].status;
   assign rsp.generation     = slot_ff[0].generation;
   assign rsp.stated_length  = slot_ff[0].stated_length;
   assign rsp.final_res      = slot_ff[0].final_res;

   assign b   = in_data.data_byte;
   assign pos = byte_offset_ff;

   always_comb begin
      key_count_in   = key_count_ff;
      key_crc_in     = key_crc_ff;
      byte_offset_in = byte_offset_ff;
      record_crc_in  = record_crc_ff;
      header_bad_in  = header_bad_ff;
      decl_len_in    = decl_len_ff;
      gen_in         = gen_ff;
      chk_in         = chk_ff;
      want_pay       = 1'b0;
      want_sta       = 1'b0;
      expect_b       = 8'd0;
      check_b        = 1'b0;
      tag            = ~key_crc_ff;
      crc_step       = crc_byte(record_crc_ff, b);
      st             = ST_OK;
      g_out          = 32'd0;
      l_out          = 13'd0;
      if (take) begin
         if (in_data.func == FuncKey) begin
            if (byte_offset_ff != 13'd0) begin
               byte_offset_in = '0;
               record_crc_in  = '1;
               header_bad_in  = 1'b0;
               decl_len_in    = '0;
               gen_in         = '0;
               chk_in         = '0;
               key_crc_in     = crc_byte('1, b);
               key_count_in   = 7'd1;
            end else begin
               key_crc_in = crc_byte(key_crc_ff, b);
               if (key_count_ff <= KeyMax) begin
                  key_count_in = key_count_ff + 7'd1;
               end
            end
         end else begin
            if (pos >= OffsetMax) begin
               header_bad_in = 1'b1;
            end else begin
               byte_offset_in = pos + 13'd1;
            end
            if (pos < CrcHdrEnd) begin
               record_crc_in = crc_step;
               check_b = 1'b1;
               priority if (pos == 13'd0) expect_b = MagicR;
               else if (pos == 13'd1) expect_b = MagicN;
               else if (pos == 13'd2) expect_b = MagicS;
               else if (pos == 13'd3) expect_b = MagicN;
               else if (pos == 13'd4) expect_b = record_version[15:8];
               else if (pos == 13'd5) expect_b = record_version[7:0];
               else if (pos == 13'd6) expect_b = 8'd0;
               else if (pos == 13'd7) expect_b = HdrSize[7:0];
               else if (pos < 13'd12) begin
                  check_b = 1'b0;
                  gen_in  = {gen_ff[23:0], b};
               end else if (pos < 13'd16) begin
                  // tag bytes most significant first
                  expect_b = tag[{~pos[1:0], 3'b000} +: 8];
               end else begin
                  check_b     = 1'b0;
                  decl_len_in = {decl_len_ff[23:0], b};
                  if (pos == 13'd19 && decl_len_in > MaxPayload) begin
                     header_bad_in = 1'b1;
                  end
               end
               if (check_b && b != expect_b) begin
                  header_bad_in = 1'b1;
               end
            end else if (pos < HdrSize) begin
               chk_in = {chk_ff[23:0], b};
            end else begin
               record_crc_in = crc_step;
               want_pay      = 1'b1;
            end
            if (in_data.last) begin
               want_sta = 1'b1;
               if (key_count_ff == 7'd0 || key_count_ff > KeyMax) begin
                  st = ST_BAD_KEY;
               end else if (byte_offset_in < HdrSize || header_bad_in ||
                            decl_len_in > MaxPayload ||
                            {19'd0, byte_offset_in} != 32'd24 + decl_len_in ||
                            ~record_crc_in != chk_in) begin
                  st = ST_MALFORMED;
               end else if (gen_in == 32'd0) begin
                  st    = ST_MALFORMED;
                  l_out = decl_len_in[12:0];
               end else begin
                  g_out = gen_in;
                  l_out = decl_len_in[12:0];
                  st    = (output_capacity < decl_len_in[12:0]) ? ST_OVERFLOW : ST_OK;
               end
               key_count_in   = '0;
               key_crc_in     = '1;
               byte_offset_in = '0;
               record_crc_in  = '1;
               header_bad_in  = 1'b0;
               decl_len_in    = '0;
               gen_in         = '0;
               chk_in         = '0;
            end
         end
      end
      pay_res = '{kind: KindPayload, payload_byte: b, status: ST_OK,
                  generation: 32'd0, stated_length: 13'd0, final_res: 1'b0};
      sta_res = '{kind: KindStatus, payload_byte: 8'd0, status: st,
                  generation: g_out, stated_length: l_out, final_res: 1'b1};
   end

   // output slot update
   always_comb begin
      logic [1:0] base;
      base       = cnt_ff - {1'b0, pop};
      slot_in[0] = pop ? slot_ff[1] : slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (want_pay && want_sta) begin
         slot_in[0] = pay_res;
         slot_in[1] = sta_res;
      end else if (want_pay || want_sta) begin
         if (base == 2'd0) slot_in[0] = want_pay ? pay_res : sta_res;
         else              slot_in[1] = want_pay ? pay_res : sta_res;
      end
      cnt_in = base + {1'b0, want_pay} + {1'b0, want_sta};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff   <= '0;
         key_crc_ff     <= '1;
         byte_offset_ff <= '0;
         record_crc_ff  <= '1;
         header_bad_ff  <= 1'b0;
         decl_len_ff    <= '0;
         gen_ff         <= '0;
         chk_ff         <= '0;
         cnt_ff         <= '0;
      end else begin
         key_count_ff   <= key_count_in;
         key_crc_ff     <= key_crc_in;
         byte_offset_ff <= byte_offset_in;
         record_crc_ff  <= record_crc_in;
         header_bad_ff  <= header_bad_in;
         decl_len_ff    <= decl_len_in;
         gen_ff         <= gen_in;
         chk_ff         <= chk_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end
endmodule

// File: design/storage_record_crc_checker.sv
// ----------------------------------------------------------------------------
// storage_record_crc_checker: stored record checker with crc-32 framing
// key tag, header and crc checks on a byte stream, payload passed through
// ----------------------------------------------------------------------------
// One byte per cycle: a transaction on req_ is accepted in every cycle the
// four-entry queue has room, and the checking engine drains the queue one
// byte a cycle while its output stage has room. A record byte giving both a
// payload and a status transaction holds the engine while the two leave the
// output stage, and a stalled rsp_ receiver stops the engine once that stage
// holds a result. Each byte is queued, then its result is registered in the
// output stage before rsp_ offers it. Key bytes (func 0) build the key tag and
// give no result; record bytes from offset 24 on come back as payloads, and
// the byte marked last also yields the final status transaction, which
// decides whether the payload is kept. Configuration writes on csr_ are
// always taken: the user must keep them to idle time; the block does not.
module storage_record_crc_checker import srcc_pkg::*; (
   input logic         clock,
   input logic         reset,
   srcc_req_if.sink    req,
   srcc_rsp_if.source  rsp,
   srcc_csr_if.sink    csr
);
   logic [15:0] record_version_ff;
   logic [12:0] output_capacity_ff;
   item_type    push_item, pop_item;
   logic        pop_valid, pop_ready;

   // configuration registers, written whenever offered
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_version_ff  <= 16'd1;
         output_capacity_ff <= 13'd4096;
      end else if (csr.valid) begin
         unique case (csr.index)
            CsrVersion:  record_version_ff  <= csr.data;
            CsrCapacity: output_capacity_ff <= csr.data[12:0];
            default: ;
         endcase
      end
   end

   // front: classify and queue the incoming byte
   assign push_item = '{func: req.func, data_byte: req.data_byte, last: req.last};

   srcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req.valid),
      .push_ready (req.ready),
      .push_data  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_item)
   );

   // back: checking engine with output stage
   srcc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .record_version  (record_version_ff),
      .output_capacity (output_capacity_ff),
      .in_valid        (pop_valid),
      .in_ready        (pop_ready),
      .in_data         (pop_item),
      .rsp             (rsp)
   );
endmodule

// File: design/srcc_checker.sv
// ----------------------------------------------------------------------------
// srcc_checker: port-level checks of the record checker
// response sanity and handshake rules
// ----------------------------------------------------------------------------
module srcc_checker import srcc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_generation,
   input logic [12:0] rsp_stated_length,
   input logic        rsp_final_res
);
   a_final_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_res == rsp_kind)) else $error("final flag mismatch");
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindPayload |->
         rsp_status == ST_OK && rsp_generation == 32'd0) else $error("dirty payload");
   a_bad_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindStatus && rsp_status == ST_BAD_KEY |->
         rsp_generation == 32'd0 && rsp_stated_length == 13'd0) else $error("bad key data");
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("valid dropped");
   a_stall_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload_byte)) else $error("payload moved");
endmodule

bind storage_record_crc_checker srcc_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_kind           (rsp.kind),
   .rsp_payload_byte   (rsp.payload_byte),
   .rsp_status         (rsp.status),
   .rsp_generation     (rsp.generation),
   .rsp_stated_length  (rsp.stated_length),
   .rsp_final_res      (rsp.final_res)
);
